// ----- design/hcbp_pkg.sv -----
// shared types and constants for the huffman code bit packer
`timescale 1ns / 1ps

package hcbp_pkg;

   localparam int WORD_BITS = 32;
   localparam int BYTE_BITS = 8;
   localparam int LEN_W     = 6;
   localparam int CNT_W     = 7;
   localparam int BYTES_W   = 3;
   localparam int KIND_W    = 2;
   localparam int SYM_W     = 8;

   typedef enum logic [KIND_W-1:0] {
      REQ_LOAD   = 2'd0,
      REQ_ENCODE = 2'd1,
      REQ_FLUSH  = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   // item held between the table read and the packer
   typedef struct packed {
      req_kind_type kind;
      logic         code_ok;
      logic [WORD_BITS-1:0] code;
      logic [LEN_W-1:0]     len;
   } pack_item_type;

   // item state captured at accept, next to the table read data
   typedef struct packed {
      req_kind_type kind;
      logic         sym_ok;
      logic         hit;
   } lookup_type;

endpackage

// ----- design/hcbp_req_if.sv -----
// request channel: valid, ready and the input word fields
`timescale 1ns / 1ps

interface hcbp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  symbol;
   logic [31:0] code_bits;
   logic [5:0]  code_len;

   modport source (output valid, output req_type, output symbol, output code_bits,
                   output code_len, input ready);
   modport sink (input valid, input req_type, input symbol, input code_bits,
                 input code_len, output ready);
endinterface

// ----- design/hcbp_rsp_if.sv -----
// response channel: valid, ready and the packed output word fields
`timescale 1ns / 1ps

interface hcbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_data;
   logic [2:0]  out_bytes;
   logic        last;

   modport source (output valid, output out_data, output out_bytes, output last,
                   input ready);
   modport sink (input valid, input out_data, input out_bytes, input last,
                 output ready);
endinterface

// ----- design/huffman_code_bit_packer_top.sv -----
// huffman code bit packer: code table, lookup stage and bit packer
// an accepted item passes the table read register, then the packer output register
// one item per cycle without back-pressure; the append and word split are combinational
// reset clears the table entry valid bits, the accumulator and all valid flags;
// a table entry never loaded since reset reads as an empty code
`timescale 1ns / 1ps

module huffman_code_bit_packer_top #(
   parameter int SYMBOLS      = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic       clock,
   input  logic       reset,
   hcbp_req_if.sink   req_chan,
   hcbp_rsp_if.source rsp_chan
);

   localparam int ADDR_W = $clog2(SYMBOLS);
   localparam int W      = hcbp_pkg::WORD_BITS;
   localparam int LW     = hcbp_pkg::LEN_W;
   localparam int RAM_W  = W + LW;

   logic                        accept;
   hcbp_pkg::req_kind_type      req_kind;
   logic                        sym_ok;
   logic [ADDR_W-1:0]           addr;
   logic [LW-1:0]               len_sat;
   logic [W:0]                  len_mask;
   logic                        wr_en;
   logic [RAM_W-1:0]            wr_data;
   logic [RAM_W-1:0]            rd_data;

   logic [SYMBOLS-1:0]          loaded_ff, loaded_in;
   logic                        s1_valid_ff, s1_valid_in;
   hcbp_pkg::lookup_type        s1_item_ff, s1_item_in;
   hcbp_pkg::pack_item_type     pack_item;
   logic                        item_taken;

   always_comb begin
      req_kind = hcbp_pkg::req_kind_type'(req_chan.req_type);
      sym_ok   = {1'b0, req_chan.symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOLS);
      addr     = req_chan.symbol[ADDR_W-1:0];
      len_sat  = (req_chan.code_len > LW'(MAX_CODE_LEN)) ? LW'(MAX_CODE_LEN)
                                                          : req_chan.code_len;
      len_mask = ~({(W + 1){1'b1}} << len_sat);
      wr_en    = accept && (req_kind == hcbp_pkg::REQ_LOAD) && sym_ok;
      wr_data  = {req_chan.code_bits & len_mask[W-1:0], len_sat};

      loaded_in = loaded_ff;
      if (wr_en) begin
         loaded_in[addr] = 1'b1;
      end

      s1_item_in.kind   = req_kind;
      s1_item_in.sym_ok = sym_ok;
      s1_item_in.hit    = loaded_ff[addr];

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (item_taken) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      pack_item.kind    = s1_item_ff.kind;
      pack_item.code_ok = s1_item_ff.sym_ok && s1_item_ff.hit;
      pack_item.code    = rd_data[RAM_W-1:LW];
      pack_item.len     = rd_data[LW-1:0];
   end

   assign req_chan.ready = !s1_valid_ff || item_taken;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         loaded_ff   <= loaded_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_item_ff <= s1_item_in;
      end
   end

   // code table: value and length side by side, read at accept
   hcbp_ram #(
      .WIDTH (RAM_W),
      .DEPTH (SYMBOLS)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   hcbp_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .item       (pack_item),
      .item_taken (item_taken),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ----- design/hcbp_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/hcbp_packer.sv -----
// bit accumulator, word emission and output register
`timescale 1ns / 1ps

module hcbp_packer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  hcbp_pkg::pack_item_type item,
   output logic                   item_taken,
   hcbp_rsp_if.source             rsp_chan
);

   localparam int W = hcbp_pkg::WORD_BITS;

   logic [W-1:0]                    acc_ff, acc_in;
   logic [hcbp_pkg::LEN_W-1:0]      cnt_ff, cnt_in;
   logic                            out_valid_ff, out_valid_in;
   logic [W-1:0]                    out_data_ff, out_data_in;
   logic [hcbp_pkg::BYTES_W-1:0]    out_bytes_ff, out_bytes_in;
   logic                            out_last_ff, out_last_in;

   logic [W-1:0]                    code_eff;
   logic [hcbp_pkg::LEN_W-1:0]      len_eff;
   logic [2*W-1:0]                  appended;
   logic [hcbp_pkg::CNT_W-1:0]      sum;
   logic [hcbp_pkg::LEN_W-1:0]      cnt_round;
   logic                            emit;
   logic [W-1:0]                    res_data;
   logic [hcbp_pkg::BYTES_W-1:0]    res_bytes;
   logic                            res_last;
   logic [W-1:0]                    acc_next;
   logic [hcbp_pkg::LEN_W-1:0]      cnt_next;

   always_comb begin
      code_eff  = item.code_ok ? item.code : '0;
      len_eff   = item.code_ok ? item.len : '0;
      appended  = {{W{1'b0}}, acc_ff} | ({{W{1'b0}}, code_eff} << cnt_ff);
      sum       = hcbp_pkg::CNT_W'(cnt_ff) + hcbp_pkg::CNT_W'(len_eff);
      cnt_round = cnt_ff + hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_BITS - 1);

      emit      = 1'b0;
      res_data  = appended[W-1:0];
      res_bytes = hcbp_pkg::BYTES_W'(W / hcbp_pkg::BYTE_BITS);
      res_last  = 1'b0;
      acc_next  = acc_ff;
      cnt_next  = cnt_ff;

      unique case (item.kind)
         hcbp_pkg::REQ_ENCODE: begin
            if (sum > hcbp_pkg::CNT_W'(W)) begin
               // more than a word pending: low word leaves
               emit     = 1'b1;
               acc_next = appended[2*W-1:W];
               cnt_next = hcbp_pkg::LEN_W'(sum - hcbp_pkg::CNT_W'(W));
            end else begin
               acc_next = appended[W-1:0];
               cnt_next = sum[hcbp_pkg::LEN_W-1:0];
            end
         end
         hcbp_pkg::REQ_FLUSH: begin
            emit      = (cnt_ff != '0);
            res_data  = acc_ff;
            res_bytes = hcbp_pkg::BYTES_W'(cnt_round >> $clog2(hcbp_pkg::BYTE_BITS));
            res_last  = 1'b1;
            acc_next  = '0;
            cnt_next  = '0;
         end
         hcbp_pkg::REQ_LOAD, hcbp_pkg::REQ_NONE: begin
            emit = 1'b0;
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      item_taken = item_valid && (!emit || !out_valid_ff || rsp_chan.ready);

      acc_in       = item_taken ? acc_next : acc_ff;
      cnt_in       = item_taken ? cnt_next : cnt_ff;
      out_data_in  = out_data_ff;
      out_bytes_in = out_bytes_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (item_taken && emit) begin
         out_valid_in = 1'b1;
         out_data_in  = res_data;
         out_bytes_in = res_bytes;
         out_last_in  = res_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff  <= out_data_in;
      out_bytes_ff <= out_bytes_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_data  = out_data_ff;
   assign rsp_chan.out_bytes = out_bytes_ff;
   assign rsp_chan.last      = out_last_ff;

endmodule

// ----- sim/huffman_code_bit_packer_top_tb.sv -----
// self-checking testbench for the huffman code bit packer: table loads, encode stream, flush
`timescale 1ns / 1ps

module huffman_code_bit_packer_top_tb;

   localparam int CLOCK_PERIOD = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int STALL_CYCLES = 300;
   localparam int TABLE_SIZE   = 256;
   localparam int CODE_MAX     = 32;
   localparam int REPORT_MAX   = 10;
   localparam int WB           = hcbp_pkg::WORD_BITS;

   typedef struct packed {
      hcbp_pkg::req_kind_type          kind;
      logic [hcbp_pkg::SYM_W-1:0]      symbol;
      logic [hcbp_pkg::WORD_BITS-1:0]  code_bits;
      logic [hcbp_pkg::LEN_W-1:0]      code_len;
   } code_req_type;

   typedef struct packed {
      logic [hcbp_pkg::WORD_BITS-1:0]  data;
      logic [hcbp_pkg::BYTES_W-1:0]    nbytes;
      logic                            last;
   } packed_word_type;

   logic clock = 1'b0;
   logic reset;

   hcbp_req_if req_chan ();
   hcbp_rsp_if rsp_chan ();

   huffman_code_bit_packer_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // predictor state
   logic [hcbp_pkg::WORD_BITS-1:0] code_table [TABLE_SIZE];
   logic [hcbp_pkg::LEN_W-1:0]     len_table [TABLE_SIZE];
   logic [63:0]                    bit_acc;
   logic [hcbp_pkg::CNT_W-1:0]     bit_count;

   packed_word_type expected_words [$];

   int fail_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_reqs = 0;
   int stall_seen = 0;
   int stall_left = 0;
   int cycle_count = 0;

   function automatic logic [63:0] low_bits(input int n);
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
   endfunction

   // returns 1 when the request produces a word
   function automatic logic pack_request(input code_req_type r, output packed_word_type w);
      int len;
      int clen;
      w = '0;
      case (r.kind)
         hcbp_pkg::REQ_LOAD: begin
            len = (int'(r.code_len) > CODE_MAX) ? CODE_MAX : int'(r.code_len);
            len_table[r.symbol]  = len[hcbp_pkg::LEN_W-1:0];
            code_table[r.symbol] = WB'({32'd0, r.code_bits} & low_bits(len));
            return 1'b0;
         end
         hcbp_pkg::REQ_ENCODE: begin
            clen = int'(len_table[r.symbol]);
            if (clen > 0) begin
               bit_acc   = bit_acc | (({32'd0, code_table[r.symbol]} & low_bits(clen))
                                      << bit_count);
               bit_count = bit_count + clen[hcbp_pkg::CNT_W-1:0];
            end
            if (int'(bit_count) > WB) begin
               w.data    = bit_acc[WB-1:0];
               w.nbytes  = 3'd4;
               w.last    = 1'b0;
               bit_acc   = bit_acc >> WB;
               bit_count = hcbp_pkg::CNT_W'(int'(bit_count) - WB);
               return 1'b1;
            end
            return 1'b0;
         end
         hcbp_pkg::REQ_FLUSH: begin
            if (bit_count == 0)
               return 1'b0;
            w.data    = WB'(bit_acc & low_bits(int'(bit_count)));
            w.nbytes  = hcbp_pkg::BYTES_W'((int'(bit_count) + hcbp_pkg::BYTE_BITS - 1)
                                           / hcbp_pkg::BYTE_BITS);
            w.last    = 1'b1;
            bit_acc   = '0;
            bit_count = '0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic send_item(input hcbp_pkg::req_kind_type kind, input int sym,
                            input logic [hcbp_pkg::WORD_BITS-1:0] bits, input int len);
      code_req_type r;
      packed_word_type w;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      r.kind      = kind;
      r.symbol    = sym[hcbp_pkg::SYM_W-1:0];
      r.code_bits = bits;
      r.code_len  = len[hcbp_pkg::LEN_W-1:0];
      req_chan.valid     <= 1'b1;
      req_chan.req_type  <= r.kind;
      req_chan.symbol    <= r.symbol;
      req_chan.code_bits <= r.code_bits;
      req_chan.code_len  <= r.code_len;
      do @(posedge clock); while (!req_chan.ready);
      if (pack_request(r, w))
         expected_words.push_back(w);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
   endtask

   function automatic int random_len();
      int p;
      p = $urandom_range(99);
      if (p < 5)  return 0;
      if (p < 75) return $urandom_range(16, 1);
      if (p < 90) return $urandom_range(32, 17);
      return $urandom_range(63, 33);
   endfunction

   function automatic int random_symbol();
      return ($urandom_range(99) < 80) ? $urandom_range(31) : $urandom_range(255);
   endfunction

   task automatic test_empty_and_ignored();
      send_item(hcbp_pkg::REQ_ENCODE, 5, $urandom, $urandom_range(63));
      send_item(hcbp_pkg::REQ_FLUSH, $urandom_range(255), $urandom, $urandom_range(63));
      send_item(hcbp_pkg::REQ_NONE, $urandom_range(255), $urandom, $urandom_range(63));
   endtask

   task automatic test_code_lengths();
      // empty code appends nothing
      send_item(hcbp_pkg::REQ_LOAD, 0, 32'hFFFF_FFFF, 0);
      send_item(hcbp_pkg::REQ_ENCODE, 0, '0, 0);
      // lengths above the limit saturate
      send_item(hcbp_pkg::REQ_LOAD, 255, 32'hFFFF_FFFF, 63);
      send_item(hcbp_pkg::REQ_LOAD, 1, 32'h1234_5678, 33);
      send_item(hcbp_pkg::REQ_LOAD, 2, 32'hFFFF_FFFF, 1);
      send_item(hcbp_pkg::REQ_LOAD, 3, 32'hFFFF_FFA5, 8);
      // exactly a full word pending stays put until flush
      repeat (4) send_item(hcbp_pkg::REQ_ENCODE, 3, '0, 0);
      send_item(hcbp_pkg::REQ_FLUSH, 0, '0, 0);
      send_item(hcbp_pkg::REQ_ENCODE, 2, '0, 0);
      send_item(hcbp_pkg::REQ_FLUSH, 0, '0, 0);
      send_item(hcbp_pkg::REQ_ENCODE, 255, '0, 0);
      send_item(hcbp_pkg::REQ_ENCODE, 255, '0, 0);
      send_item(hcbp_pkg::REQ_ENCODE, 2, '0, 0);
      send_item(hcbp_pkg::REQ_ENCODE, 1, '0, 0);
      send_item(hcbp_pkg::REQ_FLUSH, 0, '0, 0);
      // load then use in the next cycle
      send_item(hcbp_pkg::REQ_LOAD, 4, 32'h8000_0001, 32);
      send_item(hcbp_pkg::REQ_ENCODE, 4, '0, 0);
      send_item(hcbp_pkg::REQ_FLUSH, 0, '0, 0);
      send_item(hcbp_pkg::REQ_NONE, 255, 32'hFFFF_FFFF, 63);
   endtask

   task automatic test_random_stream(input int count, input int send_pct, input int recv_pct);
      int p;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) begin
         p = $urandom_range(99);
         if (p < 8)
            send_item(hcbp_pkg::REQ_LOAD, random_symbol(), $urandom, random_len());
         else if (p < 88)
            send_item(hcbp_pkg::REQ_ENCODE, random_symbol(), $urandom, $urandom_range(63));
         else if (p < 95)
            send_item(hcbp_pkg::REQ_FLUSH, $urandom_range(255), $urandom,
                      $urandom_range(63));
         else
            send_item(hcbp_pkg::REQ_NONE, $urandom_range(255), $urandom,
                      $urandom_range(63));
      end
   endtask

   task automatic test_backpressure();
      int i;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (i = 0; i < 32; i++)
         send_item(hcbp_pkg::REQ_LOAD, i, $urandom, $urandom_range(32, 12));
      // receiver holds off while the sender keeps offering encode requests
      stall_reqs++;
      repeat (150) send_item(hcbp_pkg::REQ_ENCODE, $urandom_range(31), $urandom,
                             $urandom_range(63));
      send_item(hcbp_pkg::REQ_FLUSH, 0, '0, 0);
   endtask

   task automatic test_drain_pause();
      repeat (40) send_item(hcbp_pkg::REQ_ENCODE, $urandom_range(31), $urandom,
                            $urandom_range(63));
      wait_drained();
      send_item(hcbp_pkg::REQ_ENCODE, $urandom_range(31), $urandom, $urandom_range(63));
      send_item(hcbp_pkg::REQ_FLUSH, 0, '0, 0);
   endtask

   task automatic report_fail(input string what, input packed_word_type e,
                              input packed_word_type a);
      fail_count++;
      if (fail_count <= REPORT_MAX)
         $display("%s: expected data %h bytes %0d last %0d, got data %h bytes %0d last %0d",
                  what, e.data, e.nbytes, e.last, a.data, a.nbytes, a.last);
   endtask

   // receiver ready, with an occasional long hold-off
   always @(posedge clock) begin
      if (stall_reqs != stall_seen) begin
         stall_seen = stall_reqs;
         stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each word with the oldest prediction
   always @(posedge clock) begin
      packed_word_type got;
      packed_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.data   = rsp_chan.out_data;
         got.nbytes = rsp_chan.out_bytes;
         got.last   = rsp_chan.last;
         if (expected_words.size() == 0) begin
            report_fail("unexpected word", '0, got);
         end else begin
            want = expected_words.pop_front();
            if (got.data !== want.data || got.nbytes !== want.nbytes || got.last !== want.last)
               report_fail("word mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int i;
      for (i = 0; i < TABLE_SIZE; i++) begin
         code_table[i] = '0;
         len_table[i]  = '0;
      end
      bit_acc   = '0;
      bit_count = '0;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.req_type  <= hcbp_pkg::REQ_NONE;
      req_chan.symbol    <= '0;
      req_chan.code_bits <= '0;
      req_chan.code_len  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_ignored();
      test_code_lengths();
      test_random_stream(450, 16, 68);
      test_backpressure();
      test_random_stream(450, 68, 16);
      test_drain_pause();
      test_random_stream(450, 0, 0);

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_words.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/hcbp_pkg.sv
design/hcbp_req_if.sv
design/hcbp_rsp_if.sv
design/hcbp_ram.sv
design/hcbp_packer.sv
design/huffman_code_bit_packer_top.sv
sim/huffman_code_bit_packer_top_tb.sv
